FILE: hdl/mie_pkg.sv
// shared types, widths and microcode encodings for the modular inverse unit
// no dependencies; imported by the sequencer, the datapath and the top level
package mie_pkg;

	// operand width, derived divide counter width and step counter width
	localparam int W     = 32;
	localparam int CNT_W = $clog2(W);
	localparam int PC_W  = 4;

	typedef logic [W-1:0]     word_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [PC_W-1:0]  pc_t;
	typedef logic [3:0]       op_t;
	typedef logic [2:0]       cond_t;

	// datapath operations
	localparam op_t OP_NOP      = 4'd0;
	localparam op_t OP_LOAD     = 4'd1;
	localparam op_t OP_DIV_INIT = 4'd2;
	localparam op_t OP_DIV_STEP = 4'd3;
	localparam op_t OP_MUL      = 4'd4;
	localparam op_t OP_UPD      = 4'd5;
	localparam op_t OP_SEL      = 4'd6;
	localparam op_t OP_WRAP     = 4'd7;
	localparam op_t OP_FAIL     = 4'd8;
	localparam op_t OP_EMIT     = 4'd9;

	// jump conditions
	localparam cond_t C_NONE     = 3'd0;
	localparam cond_t C_ALWAYS   = 3'd1;
	localparam cond_t C_NO_IN    = 3'd2;
	localparam cond_t C_BAD      = 3'd3;
	localparam cond_t C_R1_ZERO  = 3'd4;
	localparam cond_t C_DIV_BUSY = 3'd5;
	localparam cond_t C_R0_NE1   = 3'd6;
	localparam cond_t C_OUT_BUSY = 3'd7;

	// program addresses
	localparam pc_t A_WAIT     = 4'd0;
	localparam pc_t A_CHECK    = 4'd1;
	localparam pc_t A_LOOP     = 4'd2;
	localparam pc_t A_DIV_INIT = 4'd3;
	localparam pc_t A_DIV_STEP = 4'd4;
	localparam pc_t A_MUL      = 4'd5;
	localparam pc_t A_UPD      = 4'd6;
	localparam pc_t A_DONE     = 4'd7;
	localparam pc_t A_WRAP     = 4'd8;
	localparam pc_t A_OUT_WAIT = 4'd9;
	localparam pc_t A_EMIT     = 4'd10;
	localparam pc_t A_FAIL     = 4'd11;
	localparam int  PROG_LEN   = 12;

	// one control word of the program
	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ctrl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic bad;
		logic r1_zero;
		logic r0_ne1;
		logic div_busy;
	} status_t;

endpackage

FILE: hdl/mie_sequencer.sv
// microcode sequencer: program rom, step counter and conditional jumps
// depends on mie_pkg
module mie_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  mie_pkg::status_t status,
	input  logic            in_valid,
	input  logic            out_busy,
	output mie_pkg::ctrl_t  ctrl
);
	import mie_pkg::*;

	// program: after each op, jump to target when cond holds, else fall through
	localparam ctrl_t ROM [PROG_LEN] = '{
		'{op: OP_LOAD,     cond: C_NO_IN,    target: A_WAIT},
		'{op: OP_NOP,      cond: C_BAD,      target: A_FAIL},
		'{op: OP_NOP,      cond: C_R1_ZERO,  target: A_DONE},
		'{op: OP_DIV_INIT, cond: C_NONE,     target: A_DIV_STEP},
		'{op: OP_DIV_STEP, cond: C_DIV_BUSY, target: A_DIV_STEP},
		'{op: OP_MUL,      cond: C_NONE,     target: A_UPD},
		'{op: OP_UPD,      cond: C_ALWAYS,   target: A_LOOP},
		'{op: OP_SEL,      cond: C_R0_NE1,   target: A_FAIL},
		'{op: OP_WRAP,     cond: C_NONE,     target: A_OUT_WAIT},
		'{op: OP_NOP,      cond: C_OUT_BUSY, target: A_OUT_WAIT},
		'{op: OP_EMIT,     cond: C_ALWAYS,   target: A_WAIT},
		'{op: OP_FAIL,     cond: C_ALWAYS,   target: A_OUT_WAIT}
	};

	pc_t  pc_q;
	logic take;

	assign ctrl = ROM[pc_q];

	// condition select
	always_comb begin
		unique case (ctrl.cond)
			C_NONE:     take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_IN:    take = !in_valid;
			C_BAD:      take = status.bad;
			C_R1_ZERO:  take = status.r1_zero;
			C_DIV_BUSY: take = status.div_busy;
			C_R0_NE1:   take = status.r0_ne1;
			C_OUT_BUSY: take = out_busy;
			default:    take = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= A_WAIT;
		end else if (take) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + pc_t'(1);
		end
	end

	// the program never runs past its last word
	assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= A_FAIL)
		else $error("step counter left the program");

	// the divide loop is only entered from its init step or itself
	assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == A_DIV_STEP) |-> ($past(pc_q) == A_DIV_INIT || $past(pc_q) == A_DIV_STEP))
		else $error("divide step reached out of order");

	// an accepted item always moves on to the range check
	assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == A_WAIT && in_valid) |=> (pc_q == A_CHECK))
		else $error("accepted item did not advance");

endmodule

FILE: hdl/mie_datapath.sv
// datapath: remainder and cofactor registers, bit-serial divider,
// multiplier, result select and output register; depends on mie_pkg
module mie_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  mie_pkg::ctrl_t   ctrl,
	input  logic             in_valid,
	input  mie_pkg::word_t   value,
	input  mie_pkg::word_t   modulus,
	input  logic             out_ready,
	output mie_pkg::status_t status,
	output logic             out_busy,
	output logic             out_valid,
	output mie_pkg::word_t   inverse,
	output logic             no_inverse
);
	import mie_pkg::*;

	word_t  r0_q, r1_q, t0_q, t1_q, m_q;
	logic   neg_q;
	word_t  rem_q, qs_q;
	cnt_t   cnt_q;
	word_t  prod_q;
	word_t  res_q;
	logic   fail_q;
	logic   out_valid_q;
	word_t  inverse_q;
	logic   no_inverse_q;

	logic [W:0]   shifted, diff;
	logic         ge;
	logic [2*W-1:0] prod_full;

	// restoring divide: one quotient bit per step
	assign shifted   = {rem_q, qs_q[W-1]};
	assign diff      = shifted - {1'b0, r1_q};
	assign ge        = !diff[W];
	assign prod_full = qs_q * t1_q;

	// status for jumps
	assign status.bad      = (r0_q < word_t'(2)) || (r1_q == '0) || (r1_q >= r0_q);
	assign status.r1_zero  = (r1_q == '0);
	assign status.r0_ne1   = (r0_q != word_t'(1));
	assign status.div_busy = (cnt_q != cnt_t'(W - 1));

	assign out_busy   = out_valid_q && !out_ready;
	assign out_valid  = out_valid_q;
	assign inverse    = inverse_q;
	assign no_inverse = no_inverse_q;

	// working registers
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_LOAD: begin
				if (in_valid) begin
					r0_q   <= modulus;
					r1_q   <= value;
					m_q    <= modulus;
					t0_q   <= '0;
					t1_q   <= word_t'(1);
					neg_q  <= 1'b0;
				end
			end
			OP_DIV_INIT: begin
				rem_q <= '0;
				qs_q  <= r0_q;
				cnt_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
				qs_q  <= {qs_q[W-2:0], ge};
				cnt_q <= cnt_q + cnt_t'(1);
			end
			OP_MUL: begin
				prod_q <= prod_full[W-1:0];
			end
			OP_UPD: begin
				r0_q  <= r1_q;
				r1_q  <= rem_q;
				t0_q  <= t1_q;
				t1_q  <= t0_q + prod_q;
				neg_q <= !neg_q;
			end
			OP_SEL: begin
				res_q  <= neg_q ? t0_q : (m_q - t0_q);
				fail_q <= 1'b0;
			end
			OP_WRAP: begin
				if (res_q >= m_q) begin
					res_q <= res_q - m_q;
				end
			end
			OP_FAIL: begin
				res_q  <= '0;
				fail_q <= 1'b1;
			end
			OP_NOP, OP_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_EMIT) begin
			inverse_q    <= res_q;
			no_inverse_q <= fail_q;
		end
	end

	// a failed item always carries a zero inverse
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && no_inverse_q) |-> (inverse_q == '0))
		else $error("no_inverse item with nonzero inverse");

	// the divider never runs with a zero divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_DIV_STEP) |-> (r1_q != '0))
		else $error("divide step with zero divisor");

	// a new item is never written over a waiting one
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_EMIT) |-> !out_valid_q)
		else $error("output register overwritten");

endmodule

FILE: hdl/modular_inverse_euclid_unit.sv
// Modular inverse unit, extended Euclid with a microcoded sequencer.
// Channels: input item (value, modulus) on in_valid/in_ready, result item
// (inverse, no_inverse) on out_valid/out_ready; one result per input item.
// in_ready is high only while the sequencer sits at its wait step, so one
// item is worked on at a time. Each Euclid step is a zero test, a divider
// init, a divide step per quotient bit (one quotient bit per cycle in a
// restoring divider), one multiply and one register update. Around the
// loop come accept, range check, final zero test, gcd test with result
// select, wrap, output wait and emit; out-of-range items go from the range
// check to the fail step. For 32-bit operands an item needs at most 45
// division steps. The next item can be taken in the cycle after a result
// is loaded into the output register, which holds it while the receiver
// stalls; a second result waits in the datapath until the first is taken.
// Reset clears the step counter and the output valid flag; no item is kept
// across reset. no_inverse is set, with inverse 0, when the modulus is
// below 2, value is 0 or not below modulus, or gcd is not 1.
// depends on mie_pkg, mie_sequencer and mie_datapath
module modular_inverse_euclid_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mie_pkg::word_t value,
	input  mie_pkg::word_t modulus,
	output logic           out_valid,
	input  logic           out_ready,
	output mie_pkg::word_t inverse,
	output logic           no_inverse
);
	import mie_pkg::*;

	ctrl_t   ctrl;
	status_t status;
	logic    out_busy;

	// input is taken only at the load step
	assign in_ready = (ctrl.op == OP_LOAD);

	mie_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.in_valid (in_valid),
		.out_busy (out_busy),
		.ctrl     (ctrl)
	);

	mie_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.in_valid   (in_valid),
		.value      (value),
		.modulus    (modulus),
		.out_ready  (out_ready),
		.status     (status),
		.out_busy   (out_busy),
		.out_valid  (out_valid),
		.inverse    (inverse),
		.no_inverse (no_inverse)
	);

endmodule

FILE: tb/testbench.sv
// self-checking testbench for modular_inverse_euclid_unit: directed and random items, both
// channels throttled at random, every result checked against an in-bench extended Euclid model
// depends on mie_pkg and the modular_inverse_euclid_unit RTL
module testbench;

	import mie_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int RANDOM_ITEMS  = 350;
	localparam int QUIET_ITEMS   = 40;
	localparam int HOLD_CYCLES   = 6000;
	localparam int HOLD_AFTER    = 60;
	localparam int STALL_LIMIT   = 40000;
	localparam int SETTLE_CYCLES = 2000;
	localparam int MAX_REPORTS   = 10;

	// one input item waiting for the driver
	typedef struct {
		word_t value;
		word_t modulus;
		bit    drain_first;
	} operand_pair_t;

	// expected result item, with the operands kept for messages
	typedef struct {
		word_t value;
		word_t modulus;
		word_t inverse;
		logic  no_inverse;
	} inverse_expect_t;

	logic  clk        = 1'b0;
	logic  arst_n     = 1'b0;
	logic  in_valid   = 1'b0;
	logic  in_ready;
	word_t value      = '0;
	word_t modulus    = '0;
	logic  out_valid;
	logic  out_ready  = 1'b0;
	word_t inverse;
	logic  no_inverse;

	operand_pair_t   pending_pairs[$];
	inverse_expect_t expected_inverses[$];

	logic  in_accepted  = 1'b0;
	logic  quiet_tail   = 1'b0;
	int    send_gap     = 0;
	int    stall_left   = 0;
	int    hold_left    = 0;
	bit    hold_done    = 1'b0;
	int    results_seen = 0;
	int    mismatches   = 0;
	int    idle_cycles  = 0;
	inverse_expect_t want;
	operand_pair_t   next_pair;

	modular_inverse_euclid_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.modulus    (modulus),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.inverse    (inverse),
		.no_inverse (no_inverse)
	);

	always #HALF_PERIOD clk = ~clk;

	// extended euclid on magnitudes with a parity bit for the cofactor sign
	function automatic inverse_expect_t predict_inverse(word_t a, word_t m);
		logic [63:0] r_prev, r_cur, r_next, quot;
		logic [63:0] t_prev, t_cur, t_next, x;
		logic        odd_steps;
		inverse_expect_t res;
		res.value      = a;
		res.modulus    = m;
		res.inverse    = '0;
		res.no_inverse = 1'b1;
		if (m < 2 || a == 0 || a >= m)
			return res;
		r_prev    = 64'(m);
		r_cur     = 64'(a);
		t_prev    = 64'd0;
		t_cur     = 64'd1;
		odd_steps = 1'b0;
		while (r_cur != 0) begin
			quot      = r_prev / r_cur;
			r_next    = r_prev - quot * r_cur;
			t_next    = t_prev + quot * t_cur;
			r_prev    = r_cur;
			r_cur     = r_next;
			t_prev    = t_cur;
			t_cur     = t_next;
			odd_steps = ~odd_steps;
		end
		// gcd must be one; cofactor sign picks t or m - t
		if (r_prev != 1)
			return res;
		x = odd_steps ? t_prev : 64'(m) - t_prev;
		if (x >= 64'(m))
			x = x - 64'(m);
		res.inverse    = x[W-1:0];
		res.no_inverse = 1'b0;
		return res;
	endfunction

	task automatic queue_pair(word_t a, word_t m, bit drain);
		operand_pair_t p;
		p.value       = a;
		p.modulus     = m;
		p.drain_first = drain;
		pending_pairs.push_back(p);
	endtask

	// sender: new item or idle burst at the falling edge once the last one was taken
	always @(negedge clk) begin
		quiet_tail <= (pending_pairs.size() <= QUIET_ITEMS);
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_accepted) begin
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_pairs.size() == 0 ||
			             (pending_pairs[0].drain_first && expected_inverses.size() != 0)) begin
				in_valid <= 1'b0;
			end else if (!quiet_tail && $urandom_range(4, 0) == 0) begin
				in_valid <= 1'b0;
				send_gap <= $urandom_range(9, 0);
			end else begin
				next_pair = pending_pairs.pop_front();
				value     <= next_pair.value;
				modulus   <= next_pair.modulus;
				in_valid  <= 1'b1;
			end
		end
	end

	// receiver: random stall bursts plus one long hold-off that backs up the block
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet_tail && $urandom_range(5, 0) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(9, 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: predict on input handshake, compare on output handshake
	always @(posedge clk) begin
		in_accepted <= in_valid && in_ready;
		if (in_valid && in_ready)
			expected_inverses.push_back(predict_inverse(value, modulus));
		if (out_valid && out_ready) begin
			results_seen = results_seen + 1;
			if (expected_inverses.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result item: inverse %h no_inverse %b",
					         inverse, no_inverse);
			end else begin
				want = expected_inverses.pop_front();
				if (inverse !== want.inverse || no_inverse !== want.no_inverse) begin
					mismatches = mismatches + 1;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch value %h modulus %h: expected %h/%b got %h/%b",
						         want.value, want.modulus, want.inverse, want.no_inverse,
						         inverse, no_inverse);
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("** modular_inverse_euclid_unit: FAILED **");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		int unsigned a, m, g;
		int pick, tries;
		inverse_expect_t probe;

		// range edges
		queue_pair(32'd0, 32'd0, 1'b0);
		queue_pair(32'd0, 32'd1, 1'b0);
		queue_pair(32'd1, 32'd1, 1'b0);
		queue_pair(32'd0, 32'd7, 1'b0);
		queue_pair(32'd13, 32'd13, 1'b0);
		queue_pair(32'd20, 32'd7, 1'b0);
		queue_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
		queue_pair(32'hFFFFFFFF, 32'd5, 1'b0);
		// smallest and largest valid operands
		queue_pair(32'd1, 32'd2, 1'b0);
		queue_pair(32'd1, 32'hFFFFFFFF, 1'b0);
		queue_pair(32'hFFFFFFFE, 32'hFFFFFFFF, 1'b0);
		queue_pair(32'd2, 32'hFFFFFFFF, 1'b0);
		queue_pair(32'd3, 32'h80000000, 1'b0);
		queue_pair(32'h7FFFFFFF, 32'h80000000, 1'b0);
		queue_pair(32'd12345, 32'hFFFFFFFB, 1'b0);
		// common factor
		queue_pair(32'd6, 32'd9, 1'b0);
		queue_pair(32'h80000000, 32'hFFFFFFFE, 1'b0);
		queue_pair(32'h55555555, 32'hAAAAAAAA, 1'b0);
		// consecutive fibonacci numbers give the longest quotient chain
		queue_pair(32'd1836311903, 32'd2971215073, 1'b0);
		queue_pair(32'd1134903170, 32'd1836311903, 1'b0);

		// random part: mostly invertible pairs, small moduli keep the run short
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(9, 0);
			if (pick < 7) begin
				tries = 0;
				do begin
					if (pick < 4) begin
						m = $urandom_range(65535, 2);
					end else begin
						m = $urandom;
						if (m < 2)
							m = 2;
					end
					a = $urandom_range(m - 1, 1);
					tries++;
					probe = predict_inverse(a, m);
				end while (probe.no_inverse && tries < 16);
			end else begin
				case ($urandom_range(4, 0))
					0: begin
						a = $urandom;
						m = $urandom;
					end
					1: begin
						a = 0;
						m = $urandom;
					end
					2: begin
						a = $urandom;
						m = $urandom_range(1, 0);
					end
					3: begin
						a = $urandom;
						m = $urandom_range(a, 0);
					end
					default: begin
						g = $urandom_range(1000, 2);
						m = g * $urandom_range(1000000, 2);
						a = g * $urandom_range(m / g - 1, 1);
					end
				endcase
			end
			queue_pair(a, m, n == 0 || n == RANDOM_ITEMS / 2);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all items in, all results back, then a quiet spell for stray results
		while (pending_pairs.size() != 0 || in_valid || expected_inverses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_inverses.size() == 0)
			$display("** modular_inverse_euclid_unit: PASSED **");
		else
			$display("** modular_inverse_euclid_unit: FAILED **");
		$finish;
	end

endmodule
